@@ design/memory_pressure_classifier_core_macros.svh @@
// Assertion macros for the memory pressure classifier core.
`ifndef MEMORY_PRESSURE_CLASSIFIER_CORE_MACROS_SVH
`define MEMORY_PRESSURE_CLASSIFIER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define MPC_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("mpc assertion failed");
`define MPC_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mpc assertion failed");
`else
`define MPC_ASSERT_ALWAYS(label, expr)
`define MPC_ASSERT_IMPLIES(label, ante, cons)
`endif
`endif

@@ design/mpc_pkg.sv @@
// Types, constants and helpers shared by the memory pressure classifier.
package mpc_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned PctW  = 7;
  localparam int unsigned ProdW = WordW + PctW;
  localparam int unsigned SumW  = WordW + 2;
  localparam int unsigned Rows  = 5;

  localparam logic [PctW-1:0] PctScale    = 7'd100;
  localparam logic [PctW-1:0] DefElevated = 7'd50;
  localparam logic [PctW-1:0] DefHigh     = 7'd75;
  localparam logic [PctW-1:0] DefCritical = 7'd90;

  localparam logic [1:0] CfgElevated = 2'd0;
  localparam logic [1:0] CfgHigh     = 2'd1;
  localparam logic [1:0] CfgCritical = 2'd2;

  // largest signed word divided by 100
  localparam logic signed [WordW-1:0] HugeUsage = 64'sd92233720368547758;
  localparam logic [SumW-1:0] SumMax = {3'b000, {(WordW-1){1'b1}}};
  localparam logic signed [WordW-1:0] Unknown = -64'sd1;

  typedef enum logic [2:0] {
    BASIS_NONE  = 3'd0,
    BASIS_SOFT  = 3'd1,
    BASIS_HARD  = 3'd2,
    BASIS_AVAIL = 3'd3,
    BASIS_TOTAL = 3'd4
  } basis_t;

  typedef enum logic [1:0] {
    LVL_NOMINAL  = 2'd0,
    LVL_ELEVATED = 2'd1,
    LVL_HIGH     = 2'd2,
    LVL_CRITICAL = 2'd3
  } level_t;

  typedef struct packed {
    logic [PctW-1:0] te;
    logic [PctW-1:0] th;
    logic [PctW-1:0] tc;
  } thresh_t;

  typedef struct packed {
    basis_t                    basis;
    logic signed [WordW-1:0]   used;
    logic signed [WordW-1:0]   limit;
    logic signed [WordW-1:0]   charged;
    logic signed [WordW-1:0]   droppable;
  } usage_t;

  function automatic logic [PctW-1:0] pick_pct(input logic [PctW-1:0] r,
                                               input logic [PctW-1:0] def);
    pick_pct = (r == '0 || r > PctScale) ? def : r;
  endfunction

  function automatic thresh_t effective(input logic [PctW-1:0] e,
                                        input logic [PctW-1:0] h,
                                        input logic [PctW-1:0] c);
    thresh_t t;
    t.te = pick_pct(e, DefElevated);
    t.th = pick_pct(h, DefHigh);
    t.tc = pick_pct(c, DefCritical);
    if (!(t.te < t.th && t.th < t.tc)) begin
      t.te = DefElevated;
      t.th = DefHigh;
      t.tc = DefCritical;
    end
    effective = t;
  endfunction

endpackage

@@ design/mpc_classify.sv @@
// Percentage classification: scaled multiplies, then threshold compares.
module mpc_classify (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  mpc_pkg::usage_t     in_usage,
  input  mpc_pkg::thresh_t    thr,
  output logic                out_valid,
  output mpc_pkg::usage_t     out_usage,
  output mpc_pkg::level_t     out_level
);

  logic                          m_valid_r;
  mpc_pkg::usage_t               m_usage_r;
  logic                          m_huge_r;
  logic                          m_skip_r;
  logic [mpc_pkg::ProdW-1:0]     m_scaled_r;
  logic [mpc_pkg::ProdW-1:0]     m_lim_e_r;
  logic [mpc_pkg::ProdW-1:0]     m_lim_h_r;
  logic [mpc_pkg::ProdW-1:0]     m_lim_c_r;

  logic                          o_valid_r;
  mpc_pkg::usage_t               o_usage_r;
  mpc_pkg::level_t               o_level_r;
  mpc_pkg::level_t               level_nxt;

  logic [mpc_pkg::ProdW-1:0]     used_ext;
  logic [mpc_pkg::ProdW-1:0]     limit_ext;

  assign used_ext  = {{mpc_pkg::PctW{1'b0}}, in_usage.used};
  assign limit_ext = {{mpc_pkg::PctW{1'b0}}, in_usage.limit};

  // floor(used*100/limit) >= t  <=>  used*100 >= t*limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else begin
      m_valid_r <= in_valid;
    end
    m_usage_r  <= in_usage;
    m_huge_r   <= in_usage.used > mpc_pkg::HugeUsage;
    m_skip_r   <= in_usage.used < 0 || in_usage.limit <= 0;
    m_scaled_r <= used_ext * mpc_pkg::ProdW'(mpc_pkg::PctScale);
    m_lim_e_r  <= limit_ext * mpc_pkg::ProdW'(thr.te);
    m_lim_h_r  <= limit_ext * mpc_pkg::ProdW'(thr.th);
    m_lim_c_r  <= limit_ext * mpc_pkg::ProdW'(thr.tc);
  end

  always_comb begin
    if (m_skip_r) begin
      level_nxt = mpc_pkg::LVL_NOMINAL;
    end else if (m_huge_r || m_scaled_r >= m_lim_c_r) begin
      level_nxt = mpc_pkg::LVL_CRITICAL;
    end else if (m_scaled_r >= m_lim_h_r) begin
      level_nxt = mpc_pkg::LVL_HIGH;
    end else if (m_scaled_r >= m_lim_e_r) begin
      level_nxt = mpc_pkg::LVL_ELEVATED;
    end else begin
      level_nxt = mpc_pkg::LVL_NOMINAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else begin
      o_valid_r <= m_valid_r;
    end
    o_usage_r <= m_usage_r;
    o_level_r <= level_nxt;
  end

  assign out_valid = o_valid_r;
  assign out_usage = o_usage_r;
  assign out_level = o_level_r;

endmodule

@@ design/memory_pressure_classifier_core.sv @@
// Top level of the memory pressure classifier: basis pick, cache checks, classify.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------
//  input    | start, busy            | in_read_valid, in_cgroup_charge .. rows
//  result   | out_strobe (one cycle) | out_pressure_level .. out_trim_request
//  config   | cfg_valid, cfg_ready   | cfg_index, cfg_wdata
//
// One word can be accepted every cycle while busy is low; out_strobe follows the
// accepting edge through seven register stages (input capture, basis pick with
// pair sums, excluded sum, cache check, usage select, scaled multiplies,
// threshold compare).
// busy is high only during reset; reset clears the config registers to
// 50/75/90 and all stage valid bits. cfg_ready is always high.
// The receiver cannot stall, so the pipeline never holds.
`include "memory_pressure_classifier_core_macros.svh"

module memory_pressure_classifier_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_read_valid,
  input  logic signed [63:0]          in_cgroup_charge,
  input  logic signed [63:0]          in_cgroup_soft_limit,
  input  logic signed [63:0]          in_cgroup_hard_limit,
  input  logic signed [63:0]          in_system_total,
  input  logic signed [63:0]          in_system_available,
  input  logic signed [63:0]          in_resident_bytes,
  input  logic signed [63:0]          in_page_cache,
  input  logic signed [63:0]          in_shared_mem,
  input  logic signed [63:0]          in_locked_mem,
  input  logic signed [63:0]          in_dirty_cache,
  input  logic signed [63:0]          in_writeback_cache,
  output logic                        out_strobe,
  output logic [1:0]                  out_pressure_level,
  output logic [2:0]                  out_usage_basis,
  output logic signed [63:0]          out_used_bytes,
  output logic signed [63:0]          out_limit_bytes,
  output logic signed [63:0]          out_charged_report,
  output logic signed [63:0]          out_droppable_report,
  output logic                        out_trim_request,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [6:0]                  cfg_wdata
);

  localparam int unsigned Lat = 7;

  // config
  logic [mpc_pkg::PctW-1:0] elev_r, high_r, crit_r;
  mpc_pkg::thresh_t         thr_r;
  logic                     accept;

  assign busy      = ~rst_n;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elev_r   <= mpc_pkg::DefElevated;
      high_r   <= mpc_pkg::DefHigh;
      crit_r   <= mpc_pkg::DefCritical;
      thr_r.te <= mpc_pkg::DefElevated;
      thr_r.th <= mpc_pkg::DefHigh;
      thr_r.tc <= mpc_pkg::DefCritical;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          mpc_pkg::CfgElevated: elev_r <= cfg_wdata;
          mpc_pkg::CfgHigh:     high_r <= cfg_wdata;
          mpc_pkg::CfgCritical: crit_r <= cfg_wdata;
          default: ;
        endcase
      end
      thr_r <= mpc_pkg::effective(elev_r, high_r, crit_r);
    end
  end

  // stage 0: input capture
  logic                 s0_valid_r, s0_ok_r;
  logic signed [63:0]   s0_charge_r, s0_soft_r, s0_hard_r;
  logic signed [63:0]   s0_total_r, s0_avail_r, s0_rss_r;
  logic signed [63:0]   s0_rows_r [mpc_pkg::Rows];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= accept;
    end
    s0_ok_r      <= in_read_valid;
    s0_charge_r  <= in_cgroup_charge;
    s0_soft_r    <= in_cgroup_soft_limit;
    s0_hard_r    <= in_cgroup_hard_limit;
    s0_total_r   <= in_system_total;
    s0_avail_r   <= in_system_available;
    s0_rss_r     <= in_resident_bytes;
    s0_rows_r[0] <= in_page_cache;
    s0_rows_r[1] <= in_shared_mem;
    s0_rows_r[2] <= in_locked_mem;
    s0_rows_r[3] <= in_dirty_cache;
    s0_rows_r[4] <= in_writeback_cache;
  end

  // stage 1: basis pick, row range checks, pair sums
  mpc_pkg::basis_t      basis_nxt;
  logic signed [63:0]   limit_nxt;
  logic                 rows_bad_nxt;

  always_comb begin
    basis_nxt = mpc_pkg::BASIS_NONE;
    limit_nxt = mpc_pkg::Unknown;
    if (s0_ok_r) begin
      if (s0_charge_r >= 0 && (s0_soft_r > 0 || s0_hard_r > 0)) begin
        if (s0_soft_r > 0) begin
          basis_nxt = mpc_pkg::BASIS_SOFT;
          limit_nxt = s0_soft_r;
        end else begin
          basis_nxt = mpc_pkg::BASIS_HARD;
          limit_nxt = s0_hard_r;
        end
      end else if (s0_total_r > 0 && s0_avail_r >= 0 && s0_avail_r <= s0_total_r) begin
        basis_nxt = mpc_pkg::BASIS_AVAIL;
        limit_nxt = s0_total_r;
      end else if (s0_total_r > 0) begin
        basis_nxt = mpc_pkg::BASIS_TOTAL;
        limit_nxt = s0_total_r;
      end
    end
  end

  always_comb begin
    rows_bad_nxt = 1'b0;
    for (int i = 0; i < mpc_pkg::Rows; i++) begin
      if (s0_rows_r[i] < 0 || s0_rows_r[i] > s0_charge_r) begin
        rows_bad_nxt = 1'b1;
      end
    end
  end

  logic                 s1_valid_r, s1_rows_bad_r;
  mpc_pkg::basis_t      s1_basis_r;
  logic signed [63:0]   s1_limit_r, s1_charge_r, s1_total_r, s1_avail_r, s1_rss_r;
  logic signed [63:0]   s1_r0_r;
  logic [64:0]          s1_pair_a_r, s1_pair_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s0_valid_r;
    end
    s1_rows_bad_r <= rows_bad_nxt;
    s1_basis_r    <= basis_nxt;
    s1_limit_r    <= limit_nxt;
    s1_charge_r   <= s0_charge_r;
    s1_total_r    <= s0_total_r;
    s1_avail_r    <= s0_avail_r;
    s1_rss_r      <= s0_rss_r;
    s1_r0_r       <= s0_rows_r[0];
    s1_pair_a_r   <= {1'b0, s0_rows_r[1]} + {1'b0, s0_rows_r[2]};
    s1_pair_b_r   <= {1'b0, s0_rows_r[3]} + {1'b0, s0_rows_r[4]};
  end

  // stage 2: excluded sum
  logic                      s2_valid_r, s2_rows_bad_r;
  mpc_pkg::basis_t           s2_basis_r;
  logic signed [63:0]        s2_limit_r, s2_charge_r, s2_total_r, s2_avail_r, s2_rss_r;
  logic signed [63:0]        s2_r0_r;
  logic [mpc_pkg::SumW-1:0]  s2_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_rows_bad_r <= s1_rows_bad_r;
    s2_basis_r    <= s1_basis_r;
    s2_limit_r    <= s1_limit_r;
    s2_charge_r   <= s1_charge_r;
    s2_total_r    <= s1_total_r;
    s2_avail_r    <= s1_avail_r;
    s2_rss_r      <= s1_rss_r;
    s2_r0_r       <= s1_r0_r;
    s2_sum_r      <= {1'b0, s1_pair_a_r} + {1'b0, s1_pair_b_r};
  end

  // stage 3: droppable cache check, available-basis usage
  logic                 drop_ok;
  logic                 s3_valid_r;
  mpc_pkg::basis_t      s3_basis_r;
  logic signed [63:0]   s3_limit_r, s3_charge_r, s3_rss_r, s3_avail_used_r, s3_drop_r;

  assign drop_ok = !s2_rows_bad_r && s2_sum_r <= mpc_pkg::SumMax &&
                   s2_sum_r <= {2'b00, s2_r0_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
    s3_basis_r      <= s2_basis_r;
    s3_limit_r      <= s2_limit_r;
    s3_charge_r     <= s2_charge_r;
    s3_rss_r        <= s2_rss_r;
    s3_avail_used_r <= s2_total_r - s2_avail_r;
    s3_drop_r       <= drop_ok ? s2_r0_r - s2_sum_r[63:0] : mpc_pkg::Unknown;
  end

  // stage 4: usage select
  mpc_pkg::usage_t usage_nxt;
  logic            s4_valid_r;
  mpc_pkg::usage_t s4_usage_r;

  always_comb begin
    usage_nxt.basis     = s3_basis_r;
    usage_nxt.limit     = s3_limit_r;
    usage_nxt.used      = mpc_pkg::Unknown;
    usage_nxt.charged   = mpc_pkg::Unknown;
    usage_nxt.droppable = mpc_pkg::Unknown;
    unique case (s3_basis_r)
      mpc_pkg::BASIS_SOFT, mpc_pkg::BASIS_HARD: begin
        usage_nxt.charged   = s3_charge_r;
        usage_nxt.droppable = s3_drop_r;
        usage_nxt.used      = (s3_drop_r <= 0) ? s3_charge_r : s3_charge_r - s3_drop_r;
      end
      mpc_pkg::BASIS_AVAIL: usage_nxt.used = s3_avail_used_r;
      mpc_pkg::BASIS_TOTAL: usage_nxt.used = s3_rss_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= s3_valid_r;
    end
    s4_usage_r <= usage_nxt;
  end

  // stages 5 and 6
  logic            cls_valid;
  mpc_pkg::usage_t cls_usage;
  mpc_pkg::level_t cls_level;

  mpc_classify u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s4_valid_r),
    .in_usage  (s4_usage_r),
    .thr       (thr_r),
    .out_valid (cls_valid),
    .out_usage (cls_usage),
    .out_level (cls_level)
  );

  assign out_strobe            = cls_valid;
  assign out_pressure_level    = cls_level;
  assign out_usage_basis       = cls_usage.basis;
  assign out_used_bytes        = cls_usage.used;
  assign out_limit_bytes       = cls_usage.limit;
  assign out_charged_report    = cls_usage.charged;
  assign out_droppable_report  = cls_usage.droppable;
  // high and critical both have the upper level bit set
  assign out_trim_request      = cls_level[1];

  `MPC_ASSERT_ALWAYS(a_latency, out_strobe == $past(accept, Lat))
  `MPC_ASSERT_IMPLIES(a_none_nominal, out_strobe && out_usage_basis == mpc_pkg::BASIS_NONE, out_pressure_level == mpc_pkg::LVL_NOMINAL && out_used_bytes == mpc_pkg::Unknown)
  `MPC_ASSERT_IMPLIES(a_drop_cgroup, out_strobe && out_droppable_report != mpc_pkg::Unknown, out_usage_basis == mpc_pkg::BASIS_SOFT || out_usage_basis == mpc_pkg::BASIS_HARD)
  `MPC_ASSERT_IMPLIES(a_used_le_charge, out_strobe && (out_usage_basis == mpc_pkg::BASIS_SOFT || out_usage_basis == mpc_pkg::BASIS_HARD), out_used_bytes >= 0 && out_used_bytes <= out_charged_report)

endmodule
